### rtl/ilem_pkg.sv
// Package for the Ising lattice energy and magnetization block.
// Field widths, register reset value and parameter defaults; no dependencies.
`default_nettype none

package ilem_pkg;

    localparam int SIDE_W        = 9;
    localparam int ENERGY_W      = 19;
    localparam int MAG_W         = 17;
    localparam int SPIN_ACC_W    = 18;
    localparam int MAX_SIDE_DEF  = 256;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd64;

    typedef logic signed [ENERGY_W-1:0]   t_energy;
    typedef logic signed [SPIN_ACC_W-1:0] t_spin_acc;

endpackage

`default_nettype wire

### rtl/ising_lattice_energy_magnetization.sv
// Top level: streaming energy and magnetization of a periodic square Ising lattice.
// Holds the two row stores, the raster position and the running sums.
// Depends on ilem_pkg.
//
//   channel   direction  handshake                 payload
//   cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_side_length
//   in        in         i_in_valid  / o_in_ready   i_spin_up
//   out       out        o_out_valid / i_out_ready  o_energy_sum, o_magnetization_abs
//
// One spin per cycle; the row stores are read one column ahead with a registered port.
// The result of a lattice appears in the output register in the cycle after its last spin is accepted.
// Input stalls while a result waits and i_out_ready is low, and while i_cfg_valid is high.
// Synchronous active-low reset clears position, sums and valid; the stores need no clear.
`default_nettype none

module ising_lattice_energy_magnetization #(
    parameter int MAX_SIDE = ilem_pkg::MAX_SIDE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ilem_pkg::SIDE_W-1:0]   i_cfg_side_length,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_spin_up,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [ilem_pkg::ENERGY_W-1:0] o_energy_sum,
    output logic [ilem_pkg::MAG_W-1:0]         o_magnetization_abs
);

    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CW = (AW + 1 > ilem_pkg::SIDE_W + 1) ? AW + 1 : ilem_pkg::SIDE_W + 1;
    localparam logic [CW-1:0] MAX_SIDE_C = CW'(MAX_SIDE);
    localparam logic [CW-1:0] ONE_C      = CW'(1);

    logic [ilem_pkg::SIDE_W-1:0] r_side;
    logic [AW-1:0]               r_col, n_col;
    logic [AW-1:0]               r_row, n_row;
    logic                        r_row_start;
    logic                        r_left;
    ilem_pkg::t_energy           r_energy, n_energy;
    ilem_pkg::t_spin_acc         r_spin, n_spin;
    logic                        r_out_valid;

    logic                        mem_first [MAX_SIDE];
    logic                        mem_prev  [MAX_SIDE];
    logic                        r_first_rd;
    logic                        r_prev_rd;

    logic [CW-1:0]  w_side_ext;
    logic [CW-1:0]  w_n;
    logic [AW-1:0]  w_last;
    logic           w_accept;
    logic           w_cfg;
    logic           w_col_last;
    logic           w_row_last;
    logic           w_start;
    logic           w_top;
    logic           w_emit;
    logic [2:0]     w_en_cnt;
    logic [2:0]     w_eq_cnt;
    logic signed [4:0] w_delta;
    logic [AW-1:0]  w_rd_addr;
    logic           w_first_we;
    logic [ilem_pkg::SPIN_ACC_W-1:0] w_abs;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (!r_out_valid || i_out_ready) && !i_cfg_valid;
    assign o_out_valid = r_out_valid;

    assign w_cfg    = i_cfg_valid && o_cfg_ready;
    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        w_side_ext = CW'(r_side);
        if (w_side_ext == '0) begin
            w_n = ONE_C;
        end else if (w_side_ext > MAX_SIDE_C) begin
            w_n = MAX_SIDE_C;
        end else begin
            w_n = w_side_ext;
        end
        w_last = AW'(w_n - ONE_C);
    end

    assign w_col_last = (r_col == w_last);
    assign w_row_last = (r_row == w_last);
    assign w_start    = (r_col == '0) ? i_spin_up : r_row_start;
    assign w_top      = (r_row == '0) ? i_spin_up : r_first_rd;
    assign w_emit     = w_col_last && w_row_last;
    assign w_first_we = w_accept && (r_row == '0);

    // energy change: each enabled neighbour adds +1 if it differs, -1 if it matches
    always_comb begin
        w_en_cnt = 3'(r_col != '0) + 3'(r_row != '0) + 3'(w_col_last) + 3'(w_row_last);
        w_eq_cnt = 3'((r_col != '0) && (i_spin_up == r_left))
                 + 3'((r_row != '0) && (i_spin_up == r_prev_rd))
                 + 3'(w_col_last && (i_spin_up == w_start))
                 + 3'(w_row_last && (i_spin_up == w_top));
        w_delta  = $signed({1'b0, w_eq_cnt, 1'b0}) - $signed({2'b00, w_en_cnt});
        n_energy = r_energy - {{(ilem_pkg::ENERGY_W-5){w_delta[4]}}, w_delta};
        n_spin   = i_spin_up ? r_spin + ilem_pkg::SPIN_ACC_W'(1)
                             : r_spin - ilem_pkg::SPIN_ACC_W'(1);
        w_abs    = n_spin[ilem_pkg::SPIN_ACC_W-1] ? ilem_pkg::SPIN_ACC_W'(-n_spin)
                                                  : ilem_pkg::SPIN_ACC_W'(n_spin);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_cfg) begin
            n_col = '0;
            n_row = '0;
        end else if (w_accept) begin
            if (w_col_last) begin
                n_col = '0;
                n_row = w_row_last ? '0 : r_row + AW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    assign w_rd_addr = n_col;

    // row stores: write at the current column, read the next column with bypass
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            mem_prev[r_col] <= i_spin_up;
        end
        if (w_first_we) begin
            mem_first[r_col] <= i_spin_up;
        end
        if (w_accept && (w_rd_addr == r_col)) begin
            r_prev_rd <= i_spin_up;
        end else begin
            r_prev_rd <= mem_prev[w_rd_addr];
        end
        if (w_first_we && (w_rd_addr == r_col)) begin
            r_first_rd <= i_spin_up;
        end else begin
            r_first_rd <= mem_first[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= ilem_pkg::SIDE_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_row_start <= 1'b0;
            r_left      <= 1'b0;
            r_energy    <= '0;
            r_spin      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg) begin
                r_side      <= i_cfg_side_length;
                r_row_start <= 1'b0;
                r_left      <= 1'b0;
                r_energy    <= '0;
                r_spin      <= '0;
            end else if (w_accept) begin
                if (w_emit) begin
                    r_row_start <= 1'b0;
                    r_left      <= 1'b0;
                    r_energy    <= '0;
                    r_spin      <= '0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_row_start <= w_start;
                    r_left      <= i_spin_up;
                    r_energy    <= n_energy;
                    r_spin      <= n_spin;
                end
            end
        end
    end

    // result register: load on the last spin of a lattice
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit && !w_cfg) begin
            o_energy_sum        <= n_energy;
            o_magnetization_abs <= w_abs[ilem_pkg::MAG_W-1:0];
        end
    end

endmodule

`default_nettype wire

### bench/ising_lattice_energy_magnetization_tb.sv
`timescale 1ns / 1ps
// Testbench for ising_lattice_energy_magnetization: streams lattices of spins, predicts the
// energy and magnetization sums of each lattice and checks every result transfer.
// Depends on ilem_pkg and the block's RTL only.

module ising_lattice_energy_magnetization_tb;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int RANDOM_SPINS  = 1400;
    localparam int N_DIRECTED    = 13;

    typedef enum logic [2:0] {
        PAT_UP,
        PAT_DOWN,
        PAT_CHECKER,
        PAT_STRIPES,
        PAT_RANDOM
    } t_pattern;

    typedef struct packed {
        ilem_pkg::t_energy          energy;
        logic [ilem_pkg::MAG_W-1:0] mag;
    } t_lattice_sums;

    typedef struct packed {
        bit                          write_side;
        logic [ilem_pkg::SIDE_W-1:0] side;
        t_pattern                    pattern;
        int                          spins;
        bit                          typed;
        int                          energy;
        int                          mag;
    } t_lattice_row;

    // spins = 0 means a full lattice; typed rows carry their expected sums
    t_lattice_row directed_rows [N_DIRECTED] = '{
        '{1'b0, 9'd0,   PAT_RANDOM,  30, 1'b0, 0,       0},
        '{1'b1, 9'd0,   PAT_UP,      0,  1'b1, -2,      1},
        '{1'b0, 9'd0,   PAT_DOWN,    0,  1'b1, -2,      1},
        '{1'b1, 9'd1,   PAT_DOWN,    0,  1'b1, -2,      1},
        '{1'b1, 9'd2,   PAT_CHECKER, 0,  1'b1, 8,       0},
        '{1'b0, 9'd0,   PAT_RANDOM,  0,  1'b0, 0,       0},
        '{1'b1, 9'd3,   PAT_CHECKER, 0,  1'b0, 0,       0},
        '{1'b1, 9'd5,   PAT_RANDOM,  7,  1'b0, 0,       0},
        '{1'b1, 9'd5,   PAT_RANDOM,  0,  1'b0, 0,       0},
        '{1'b1, 9'd6,   PAT_RANDOM,  20, 1'b0, 0,       0},
        '{1'b1, 9'd4,   PAT_STRIPES, 0,  1'b1, 0,       0},
        '{1'b1, 9'd8,   PAT_UP,      0,  1'b1, -128,    64},
        '{1'b1, 9'd8,   PAT_CHECKER, 0,  1'b1, 128,     0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [ilem_pkg::SIDE_W-1:0]   i_cfg_side_length = '0;
    logic                          i_in_valid = 1'b0;
    logic                          i_spin_up = 1'b0;
    logic                          i_out_ready = 1'b0;
    logic                          o_cfg_ready;
    logic                          o_in_ready;
    logic                          o_out_valid;
    ilem_pkg::t_energy             o_energy_sum;
    logic [ilem_pkg::MAG_W-1:0]    o_magnetization_abs;

    ising_lattice_energy_magnetization u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_side_length   (i_cfg_side_length),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_spin_up           (i_spin_up),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_energy_sum        (o_energy_sum),
        .o_magnetization_abs (o_magnetization_abs)
    );

    // lattice predictor state
    logic                        first_row [ilem_pkg::MAX_SIDE_DEF];
    logic                        above_row [ilem_pkg::MAX_SIDE_DEF];
    logic                        row_first_spin;
    logic                        prev_spin;
    int                          row_pos;
    int                          col_pos;
    int                          energy_acc;
    int                          spin_acc;
    logic [ilem_pkg::SIDE_W-1:0] side_reg;

    t_lattice_sums pending_sums [$];
    t_lattice_sums typed_sums;
    bit            typed_pending = 1'b0;

    int errors = 0;
    int cycles = 0;
    int spins_sent = 0;
    int lattices_done = 0;
    int results_seen = 0;
    int side_writes = 0;
    int burst_left = 0;
    int stall_left = 0;
    int open_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int spin_value(input logic up);
        return up ? 1 : -1;
    endfunction

    function automatic int lattice_side();
        if (side_reg == 0) return 1;
        if (side_reg > ilem_pkg::MAX_SIDE_DEF) return ilem_pkg::MAX_SIDE_DEF;
        return int'(side_reg);
    endfunction

    function automatic void restart_sums();
        row_first_spin = 1'b0;
        prev_spin = 1'b0;
        row_pos = 0;
        col_pos = 0;
        energy_acc = 0;
        spin_acc = 0;
    endfunction

    // advance one spin; returns 1 with the lattice sums after its last spin
    function automatic bit lattice_sums_step(input logic up, output t_lattice_sums sums);
        int   n;
        int   s;
        int   m;
        logic start;
        logic top;
        n = lattice_side();
        s = spin_value(up);
        start = (col_pos == 0) ? up : row_first_spin;
        top = (row_pos == 0) ? up : first_row[col_pos];
        sums = '0;
        spin_acc += s;
        if (col_pos > 0) energy_acc -= s * spin_value(prev_spin);
        if (row_pos > 0) energy_acc -= s * spin_value(above_row[col_pos]);
        if (col_pos == n - 1) energy_acc -= s * spin_value(start);
        if (row_pos == n - 1) energy_acc -= s * spin_value(top);
        if (row_pos == 0) first_row[col_pos] = up;
        above_row[col_pos] = up;
        row_first_spin = start;
        prev_spin = up;
        if (col_pos + 1 < n) begin
            col_pos++;
            return 1'b0;
        end
        col_pos = 0;
        if (row_pos + 1 < n) begin
            row_pos++;
            return 1'b0;
        end
        m = (spin_acc < 0) ? -spin_acc : spin_acc;
        sums.energy = ilem_pkg::t_energy'(energy_acc);
        sums.mag = m[ilem_pkg::MAG_W-1:0];
        restart_sums();
        return 1'b1;
    endfunction

    task automatic send_spin(input logic up);
        t_lattice_sums sums;
        int            gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_spin_up <= up;
        do @(posedge i_clk); while (!o_in_ready);
        spins_sent++;
        if (lattice_sums_step(up, sums)) begin
            if (typed_pending) begin
                sums = typed_sums;
                typed_pending = 1'b0;
            end
            pending_sums.push_back(sums);
            lattices_done++;
        end
    endtask

    task automatic wait_block_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [ilem_pkg::SIDE_W-1:0] side);
        i_cfg_valid <= 1'b1;
        i_cfg_side_length <= side;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        side_reg = side;
        restart_sums();
        side_writes++;
    endtask

    task automatic stream_lattice(input t_pattern pattern, input int up_pct, input int spins);
        int   n;
        int   total;
        int   k;
        logic up;
        n = lattice_side();
        total = (spins == 0) ? n * n : spins;
        k = 0;
        for (int r = 0; r < n && k < total; r++) begin
            for (int c = 0; c < n && k < total; c++) begin
                case (pattern)
                    PAT_UP:      up = 1'b1;
                    PAT_DOWN:    up = 1'b0;
                    PAT_CHECKER: up = ((r + c) % 2) == 0;
                    PAT_STRIPES: up = (r % 2) == 0;
                    default:     up = $urandom_range(0, 99) < up_pct;
                endcase
                send_spin(up);
                k++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_sums.size());
            $display("ising_lattice_energy_magnetization_tb NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (open_left > 0) begin
            open_left--;
            i_out_ready <= 1'b1;
        end else begin
            open_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                    : $urandom_range(1, 6);
            stall_left = $urandom_range(0, 4);
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_lattice_sums want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_sums.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, energy_sum %0d magnetization_abs %0d",
                         $time, o_energy_sum, o_magnetization_abs);
            end else begin
                want = pending_sums.pop_front();
                if (o_energy_sum !== want.energy) begin
                    errors++;
                    $display("%0t: energy_sum expected %0d actual %0d",
                             $time, $signed(want.energy), o_energy_sum);
                end
                if (o_magnetization_abs !== want.mag) begin
                    errors++;
                    $display("%0t: magnetization_abs expected %0d actual %0d",
                             $time, want.mag, o_magnetization_abs);
                end
            end
        end
    end

    initial begin
        int          random_spins0;
        int          lattices;
        int          n;
        int          up_pct;
        t_lattice_row row;
        logic [ilem_pkg::SIDE_W-1:0] side;
        for (int j = 0; j < ilem_pkg::MAX_SIDE_DEF; j++) begin
            first_row[j] = 1'b0;
            above_row[j] = 1'b0;
        end
        side_reg = ilem_pkg::SIDE_RESET;
        restart_sums();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            if (row.write_side) begin
                wait_block_idle();
                write_side(row.side);
            end
            if (row.typed) begin
                typed_sums.energy = ilem_pkg::t_energy'(row.energy);
                typed_sums.mag = row.mag[ilem_pkg::MAG_W-1:0];
                typed_pending = 1'b1;
            end
            stream_lattice(row.pattern, 50, row.spins);
        end

        random_spins0 = spins_sent;
        while (spins_sent - random_spins0 < RANDOM_SPINS) begin
            case ($urandom_range(0, 19))
                0:             side = ilem_pkg::SIDE_W'($urandom_range(21, 32));
                1, 2, 3, 4, 5: side = ilem_pkg::SIDE_W'($urandom_range(9, 20));
                default:       side = ilem_pkg::SIDE_W'($urandom_range(0, 8));
            endcase
            wait_block_idle();
            write_side(side);
            n = lattice_side();
            lattices = $urandom_range(1, 4);
            for (int l = 0; l < lattices && spins_sent - random_spins0 < RANDOM_SPINS; l++) begin
                case ($urandom_range(0, 9))
                    0:       up_pct = 0;
                    1:       up_pct = 100;
                    default: up_pct = $urandom_range(0, 100);
                endcase
                if ($urandom_range(0, 9) == 0)
                    stream_lattice(t_pattern'($urandom_range(0, 3)), 0, 0);
                else
                    stream_lattice(PAT_RANDOM, up_pct, 0);
            end
            if (n > 1 && $urandom_range(0, 4) == 0)
                stream_lattice(PAT_RANDOM, 50, $urandom_range(1, n * n - 1));
        end

        wait_block_idle();
        $display("Streamed %0d spins in %0d lattices after %0d side writes.",
                 spins_sent, lattices_done, side_writes);
        $display("Checked %0d result transfers; sides 0 to 32, full and cut-short lattices.",
                 results_seen);
        if (errors == 0) begin
            $display("ising_lattice_energy_magnetization_tb OK");
        end else begin
            $display("ising_lattice_energy_magnetization_tb NOT OK");
        end
        $finish;
    end

endmodule
